>>> hdl/perspective_point_projection_defines.svh
// Assertion helpers used by the checker file.
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

// Implication checked in the same cycle.
`define PPP_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ppp assertion failed");

// Implication checked a fixed number of cycles later.
`define PPP_ASSERT_LATER(label, cond, dly, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##dly (prop)) \
        else $error("ppp latency assertion failed");

`endif

>>> hdl/ppp_pkg.sv
package ppp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SIZE_W    = 13;
    localparam int SCALE_W   = SIZE_W + FRAC_BITS;
    // clip values: 32-bit column plus three products shifted down, with headroom
    localparam int CLIP_W    = 64 - FRAC_BITS + 4;
    localparam int NMAG_W    = CLIP_W;
    localparam int PROD_W    = NMAG_W + SCALE_W;
    localparam int LO_W      = 32 + SCALE_W;
    localparam int HI_W      = NMAG_W - 32 + SCALE_W;
    localparam int DIV_W     = CLIP_W + 1;
    localparam int QBITS     = 32;
    // accept edge to result strobe
    localparam int LATENCY   = 6 + QBITS;

    localparam logic [31:0] COEF_ONE = 32'(1) << FRAC_BITS;

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } ppp_in_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               visible;
        logic               divide_error;
    } ppp_out_t;

endpackage

>>> hdl/perspective_point_projection.sv
// Perspective point projection with viewport mapping, signed Q16.16.
// Input: an item is taken on a rising edge with start high and busy low.
//   busy is always low; one item may be accepted every cycle.
//   kind = load writes one matrix coefficient (no result); kind = point
//   projects (x,y,z,1) through the row-major 4x4 matrix.
// Config: cfg_we writes screen_width (index 0) or screen_height (index 1)
//   at once; other indexes are ignored. Write only while no point is in flight.
// Output: done pulses for one cycle with the result beat on result.
//   Throughput is one point per cycle. The result passes the 32-stage
//   quotient pipeline (one quotient bit per stage, 54-bit compare and
//   subtract), after six stages of matrix multiply, clip sum, magnitude,
//   viewport scale multiply, product join and setup, plus the output
//   register.
// A load takes effect for the next accepted point; points already in
//   flight keep the coefficients they were multiplied with.
// Reset: matrix returns to identity, viewport to 640x480, pipeline empties.
// The receiver cannot stall; every beat is shown for exactly one cycle.
module perspective_point_projection (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ppp_pkg::ppp_in_t      cmd,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    output logic                  done,
    output ppp_pkg::ppp_out_t     result
);
    import ppp_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] q;
        logic             ovf;
    } div_t;

    typedef struct packed {
        logic derr;
        logic vis;
        logic negx;
        logic negy;
    } tag_t;

    logic [31:0]              coef_reg [16];
    logic [SIZE_W-1:0]        width_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic [LATENCY:0]         vld_reg;

    logic signed [63:0]       prod_reg [4][3];
    logic signed [31:0]       col3_reg [4];
    logic signed [CLIP_W-1:0] clip_reg [4];
    logic [NMAG_W-1:0]        nmag_reg [2];
    logic [LO_W-1:0]          plo_reg [2];
    logic [HI_W-1:0]          phi_reg [2];
    logic [PROD_W-1:0]        p_reg [2];
    logic [DIV_W-1:0]         d3_reg, d4_reg, d5_reg;
    tag_t                     t3_reg, t4_reg, t5_reg;
    logic [DIV_W-1:0]         dd_reg [QBITS+1];
    tag_t                     tg_reg [QBITS+1];
    div_t                     dv_reg [2][QBITS+1];
    ppp_out_t                 res_reg;

    logic signed [31:0]       pt [3];
    logic                     accept;

    assign pt[0]  = cmd.point_x;
    assign pt[1]  = cmd.point_y;
    assign pt[2]  = cmd.point_z;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    function automatic div_t div_step(input div_t s, input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic           ge;
        div_t           n;
        t     = {s.rem, s.low[QBITS-1]};
        ge    = t >= {1'b0, d};
        n.rem = ge ? DIV_W'(t - {1'b0, d}) : DIV_W'(t);
        n.low = s.low << 1;
        n.q   = {s.q[QBITS-2:0], ge};
        n.ovf = s.ovf;
        return n;
    endfunction

    function automatic logic [31:0] finish(input div_t s, input logic neg);
        logic [QBITS:0] c;
        c = {1'b0, s.q} + {{QBITS{1'b0}}, (s.rem != '0)};
        if (neg)
        begin
            if (s.ovf || c > {1'b1, {QBITS{1'b0}}} >> 1)
                return 32'h8000_0000;
            return 32'(-c);
        end
        if (s.ovf || s.q[QBITS-1])
            return 32'h7FFF_FFFF;
        return s.q;
    endfunction

    // configuration and coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                coef_reg[i] <= (i % 5 == 0) ? COEF_ONE : 32'd0;
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
        end
        else
        begin
            if (accept && cmd.kind == KIND_LOAD)
                coef_reg[cmd.entry_index] <= cmd.entry_value;
            if (cfg_we && cfg_index == CFG_SCREEN_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_SCREEN_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-1:0], accept && cmd.kind == KIND_POINT};
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        logic signed [CLIP_W-1:0] numx, numy, cw;
        logic [SCALE_W-1:0]       sc [2];
        logic [PROD_W-1:0]        p;

        // stage 1: matrix products
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
                prod_reg[r][c] <= $signed(coef_reg[r*4+c]) * pt[c];
            col3_reg[r] <= $signed(coef_reg[r*4+3]);
        end

        // stage 2: clip coordinates, floor shift of each product
        for (int r = 0; r < 4; r++)
            clip_reg[r] <= CLIP_W'(col3_reg[r])
                         + CLIP_W'(prod_reg[r][0] >>> FRAC_BITS)
                         + CLIP_W'(prod_reg[r][1] >>> FRAC_BITS)
                         + CLIP_W'(prod_reg[r][2] >>> FRAC_BITS);

        // stage 3: numerators, magnitudes, flags
        cw   = clip_reg[3];
        numx = clip_reg[0] + cw;
        numy = cw - clip_reg[1];
        nmag_reg[0] <= numx[CLIP_W-1] ? NMAG_W'(-numx) : NMAG_W'(numx);
        nmag_reg[1] <= numy[CLIP_W-1] ? NMAG_W'(-numy) : NMAG_W'(numy);
        d3_reg      <= {(cw[CLIP_W-1] ? CLIP_W'(-cw) : CLIP_W'(cw)), 1'b0};
        t3_reg.derr <= (cw == '0);
        t3_reg.vis  <= (cw > 0) && (clip_reg[2] > 0);
        t3_reg.negx <= numx[CLIP_W-1] ^ cw[CLIP_W-1];
        t3_reg.negy <= numy[CLIP_W-1] ^ cw[CLIP_W-1];

        // stage 4: viewport scale, split multiply
        sc[0] = SCALE_W'(width_reg) << FRAC_BITS;
        sc[1] = SCALE_W'(height_reg) << FRAC_BITS;
        for (int i = 0; i < 2; i++)
        begin
            plo_reg[i] <= LO_W'(nmag_reg[i][31:0]) * LO_W'(sc[i]);
            phi_reg[i] <= HI_W'(nmag_reg[i][NMAG_W-1:32]) * HI_W'(sc[i]);
        end
        d4_reg <= d3_reg;
        t4_reg <= t3_reg;

        // stage 5: join partial products
        for (int i = 0; i < 2; i++)
            p_reg[i] <= PROD_W'(plo_reg[i]) + (PROD_W'(phi_reg[i]) << 32);
        d5_reg <= d4_reg;
        t5_reg <= t4_reg;

        // stage 6: overflow check and divider setup
        for (int i = 0; i < 2; i++)
        begin
            p = p_reg[i];
            dv_reg[i][0].ovf <= DIV_W'(p[PROD_W-1:QBITS]) >= d5_reg;
            dv_reg[i][0].rem <= DIV_W'(p[PROD_W-1:QBITS]);
            dv_reg[i][0].low <= p[QBITS-1:0];
            dv_reg[i][0].q   <= '0;
        end
        dd_reg[0] <= d5_reg;
        tg_reg[0] <= t5_reg;

        // quotient pipeline, one bit per stage
        for (int k = 0; k < QBITS; k++)
        begin
            for (int i = 0; i < 2; i++)
                dv_reg[i][k+1] <= div_step(dv_reg[i][k], dd_reg[k]);
            dd_reg[k+1] <= dd_reg[k];
            tg_reg[k+1] <= tg_reg[k];
        end

        // rounding, saturation, zero-w override
        res_reg.visible      <= tg_reg[QBITS].vis;
        res_reg.divide_error <= tg_reg[QBITS].derr;
        if (tg_reg[QBITS].derr)
        begin
            res_reg.screen_x <= '0;
            res_reg.screen_y <= '0;
        end
        else
        begin
            res_reg.screen_x <= finish(dv_reg[0][QBITS], tg_reg[QBITS].negx);
            res_reg.screen_y <= finish(dv_reg[1][QBITS], tg_reg[QBITS].negy);
        end
    end

    assign done   = vld_reg[LATENCY];
    assign result = res_reg;

endmodule

>>> hdl/ppp_checker.sv
`include "perspective_point_projection_defines.svh"

module ppp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ppp_pkg::ppp_in_t  cmd,
    input logic              done,
    input ppp_pkg::ppp_out_t result
);
    import ppp_pkg::*;

    `PPP_ASSERT_IMPL(a_derr_zero, done && result.divide_error, result.screen_x == 0 && result.screen_y == 0 && !result.visible)
    `PPP_ASSERT_LATER(a_point_beat, start && !busy && cmd.kind == KIND_POINT, (LATENCY + 1), done)
    `PPP_ASSERT_LATER(a_load_silent, start && !busy && cmd.kind == KIND_LOAD, (LATENCY + 1), !done)
    `PPP_ASSERT_LATER(a_idle_silent, !(start && !busy), (LATENCY + 1), !done)

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (.*);

>>> tb/perspective_point_projection_tb.sv
module perspective_point_projection_tb;
    import ppp_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam longint CYCLE_LIMIT = 400000;
    // register indexes past the two real registers
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ppp_in_t cmd = '0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic done;
    ppp_out_t result;

    perspective_point_projection dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    always #2 clk = ~clk;

    // predictor state
    logic signed [31:0] coef [16];
    logic [12:0] view_w, view_h;
    ppp_out_t projections_due [$];
    int errors = 0;
    int points_sent = 0, loads_sent = 0, results_seen = 0;
    int divide_errors_seen = 0, saturations_seen = 0;
    longint cycles = 0;
    int burst_left = 0;

    function automatic logic signed [127:0] floor_q(logic signed [127:0] v);
        return v >>> FB;
    endfunction

    // floor(num * size * 2^FB / (2w)), saturated to 32 bits
    function automatic logic signed [31:0] to_screen(logic signed [127:0] num,
            logic [12:0] size, logic signed [127:0] w);
        logic signed [127:0] n, d, q;
        n = num * $signed({115'd0, size}) * (128'sd1 <<< FB);
        d = 2 * w;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        q = n / d;
        if (n % d != 0 && n < 0)
            q = q - 1;
        if (q > 128'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (q < -128'sh80000000)
            return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic ppp_out_t project_point(ppp_in_t it);
        logic signed [127:0] clip [4];
        logic signed [127:0] p [3];
        ppp_out_t r;
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        for (int row = 0; row < 4; row++)
        begin
            clip[row] = coef[row * 4 + 3];
            for (int c = 0; c < 3; c++)
                clip[row] += floor_q(128'(coef[row * 4 + c]) * p[c]);
        end
        r.visible = clip[3] > 0 && clip[2] > 0;
        if (clip[3] == 0)
        begin
            r.screen_x = 0;
            r.screen_y = 0;
            r.divide_error = 1'b1;
        end
        else
        begin
            r.screen_x = to_screen(clip[0] + clip[3], view_w, clip[3]);
            r.screen_y = to_screen(clip[3] - clip[1], view_h, clip[3]);
            r.divide_error = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        ppp_out_t exp_r;
        if (rst_n && done)
        begin
            results_seen++;
            if (projections_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = projections_due.pop_front();
                if (exp_r.divide_error)
                    divide_errors_seen++;
                if (exp_r.screen_x == 32'sh7FFFFFFF || exp_r.screen_x == 32'sh80000000)
                    saturations_seen++;
                if (result.screen_x !== exp_r.screen_x)
                begin
                    $error("screen_x exp %0d got %0d", exp_r.screen_x, result.screen_x);
                    errors++;
                end
                if (result.screen_y !== exp_r.screen_y)
                begin
                    $error("screen_y exp %0d got %0d", exp_r.screen_y, result.screen_y);
                    errors++;
                end
                if (result.visible !== exp_r.visible)
                begin
                    $error("visible exp %0b got %0b", exp_r.visible, result.visible);
                    errors++;
                end
                if (result.divide_error !== exp_r.divide_error)
                begin
                    $error("divide_error exp %0b got %0b", exp_r.divide_error,
                        result.divide_error);
                    errors++;
                end
            end
        end
    end

    // one beat; start held across back-to-back beats, dropped only in gaps
    task automatic send_item(ppp_in_t it);
        if (burst_left == 0)
        begin
            int gap;
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.kind == KIND_LOAD)
        begin
            coef[it.entry_index] = it.entry_value;
            loads_sent++;
        end
        else
        begin
            projections_due.push_back(project_point(it));
            points_sent++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (projections_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // one write, then a quiet cycle so the enable drops before the next call
    task automatic write_size(logic [1:0] idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            view_w = val;
        else if (idx == CFG_SCREEN_HEIGHT)
            view_h = val;
        @(negedge clk);
    endtask

    function automatic ppp_in_t mk_load(int idx, logic signed [31:0] v);
        logic [191:0] raw;
        ppp_in_t it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(ppp_in_t)-1:0];
        it.kind = KIND_LOAD;
        it.entry_index = 4'(idx);
        it.entry_value = v;
        return it;
    endfunction

    function automatic ppp_in_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z);
        logic [191:0] raw;
        ppp_in_t it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(ppp_in_t)-1:0];
        it.kind = KIND_POINT;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
            2: return 32'sh7FFFFFFF;
            3: return 32'sh80000000;
            default: return $signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1));
        endcase
    endfunction

    task automatic test_directed();
        // identity matrix: w = 1
        send_item(mk_point(0, 0, 0));
        send_item(mk_point(32'sh7FFFFFFF, 32'sh80000000, 1 << FB));
        send_item(mk_point(32'sh80000000, 32'sh7FFFFFFF, -(1 << FB)));
        send_item(mk_point(1 << FB, -(1 << FB), 1));
        // zero w
        send_item(mk_load(15, 0));
        send_item(mk_point(1 << FB, 1 << FB, 1 << FB));
        // w from z, perspective-like
        send_item(mk_load(14, 1 << FB));
        send_item(mk_point(1 << FB, 1 << FB, 2 << FB));
        send_item(mk_point(1 << FB, 1 << FB, -(3 << FB)));
        send_item(mk_point(5 << FB, 0, 1));
        send_item(mk_load(0, 32'sh7FFFFFFF));
        send_item(mk_load(5, 32'sh80000000));
        send_item(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        send_item(mk_point(32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_item(mk_point(-1, -1, -1));
        drain();
    endtask

    task automatic test_sizes();
        logic [12:0] sizes [5] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640};
        write_size(CFG_SPARE_A, 13'd17);
        write_size(CFG_SPARE_B, 13'd99);
        for (int s = 0; s < 5; s++)
        begin
            write_size(CFG_SCREEN_WIDTH, sizes[s]);
            write_size(CFG_SCREEN_HEIGHT, sizes[4 - s]);
            for (int i = 0; i < 6; i++)
                send_item(mk_point(rand_word(), rand_word(), rand_word()));
            drain();
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 300 == 299)
            begin
                drain();
                write_size(CFG_SCREEN_WIDTH, $urandom_range(1, 4096));
                write_size(CFG_SCREEN_HEIGHT, $urandom_range(1, 4096));
            end
            if ($urandom_range(0, 9) < 2)
            begin
                // keep w small-ish and nonzero more often than not
                int idx = $urandom_range(0, 15);
                send_item(mk_load(idx, (idx >= 12 && $urandom_range(0, 3) != 0) ?
                    $signed($urandom_range(0, 4 << FB)) - (1 << FB) : rand_word()));
            end
            else
                send_item(mk_point(rand_word(), rand_word(), rand_word()));
        end
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            coef[i] = (i % 5 == 0) ? COEF_ONE : 0;
        view_w = 640;
        view_h = 480;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_sizes();
        test_random(1300);
        $display("%0d points, %0d coefficient loads, %0d result beats checked",
            points_sent, loads_sent, results_seen);
        $display("%0d zero-w results, %0d saturated x coordinates",
            divide_errors_seen, saturations_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/ppp_pkg.sv
hdl/perspective_point_projection.sv
hdl/ppp_checker.sv
tb/perspective_point_projection_tb.sv
